### rtl/core/csh_pkg.sv
// shared types and constants of the cushion pixel shader
package csh_pkg;

	// fixed field widths
	localparam int PIX_W   = 12;
	localparam int COLOR_W = 8;

	// datapath widths
	localparam int NORM_W  = 30;
	localparam int NUM_W   = 48;
	localparam int DEN_W   = 62;
	localparam int ROOT_W  = 31;
	localparam int QUO_W   = 18;
	localparam int DVD_W   = 59;
	localparam int DVS_W   = 40;
	localparam int INT_W   = 17;
	localparam logic [INT_W-1:0] INT_MAX = 17'h1FFFF;

	// configuration port
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	typedef enum logic [2:0] {
		REG_AMBIENT,
		REG_LIGHT_X,
		REG_LIGHT_Y,
		REG_LIGHT_Z,
		REG_LIN_X,
		REG_SQ_X,
		REG_LIN_Y,
		REG_SQ_Y
	} csh_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_x;
		logic [PIX_W-1:0]   pixel_y;
		logic [COLOR_W-1:0] base_red;
		logic [COLOR_W-1:0] base_green;
		logic [COLOR_W-1:0] base_blue;
	} csh_in_t;

	typedef struct packed {
		logic [COLOR_W-1:0] shade_red;
		logic [COLOR_W-1:0] shade_green;
		logic [COLOR_W-1:0] shade_blue;
	} csh_out_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} csh_rgb_t;

	typedef struct packed {
		logic [7:0]         ambient_level;
		logic signed [15:0] light_x;
		logic signed [15:0] light_y;
		logic signed [15:0] light_z;
		logic signed [31:0] lin_coef_x;
		logic signed [31:0] sq_coef_x;
		logic signed [31:0] lin_coef_y;
		logic signed [31:0] sq_coef_y;
	} csh_cfg_t;

	// light dot product and squared normal length
	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
		csh_rgb_t                rgb;
	} csh_nd_t;

	// light dot product and normal length
	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic [ROOT_W-1:0]       root;
		csh_rgb_t                rgb;
	} csh_nr_t;

endpackage

### rtl/core/csh_front.sv
// surface normal, normalization, light dot product and squared length
module csh_front #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  csh_pkg::csh_in_t  in_d,
	input  csh_pkg::csh_cfg_t cfg,
	output logic              out_v,
	output csh_pkg::csh_nd_t  out_d
);
	import csh_pkg::*;

	localparam int EFF_W = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
	localparam int NW    = EFF_W + 34;
	localparam int MW    = NW - 1;
	localparam int NG    = (MW + 7) / 8;
	localparam int PW    = NG * 8;
	localparam int BLW   = $clog2(MW + 1);
	localparam logic [MW-1:0] ONE = MW'(1) << FRAC_BITS;

	function automatic logic [3:0] bitlen8(input logic [7:0] b);
		logic [3:0] len;
		len = 4'd0;
		for (int j = 0; j < 8; j++) begin
			if (b[j]) len = 4'(j + 1);
		end
		return len;
	endfunction

	// stage 1: square coefficient times odd coordinate
	logic                 v_s1;
	logic signed [NW-1:0] prod_x_s1, prod_y_s1;
	csh_rgb_t             rgb_s1;
	logic signed [EFF_W+1:0] odd_x, odd_y;

	assign odd_x = $signed({1'b0, in_d.pixel_x[EFF_W-1:0], 1'b1});
	assign odd_y = $signed({1'b0, in_d.pixel_y[EFF_W-1:0], 1'b1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1 <= cfg.sq_coef_x * odd_x;
			prod_y_s1 <= cfg.sq_coef_y * odd_y;
			rgb_s1    <= '{in_d.base_red, in_d.base_green, in_d.base_blue};
		end
	end

	// stage 2: add linear term, split into sign and magnitude
	logic                 v_s2;
	logic [MW-1:0]        ax_s2, ay_s2;
	logic                 sx_s2, sy_s2;
	csh_rgb_t             rgb_s2;
	logic signed [NW-1:0] nx, ny, mx, my;

	always_comb begin
		nx = prod_x_s1 + {{(NW-32){cfg.lin_coef_x[31]}}, cfg.lin_coef_x};
		ny = prod_y_s1 + {{(NW-32){cfg.lin_coef_y[31]}}, cfg.lin_coef_y};
		mx = nx[NW-1] ? -nx : nx;
		my = ny[NW-1] ? -ny : ny;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2  <= mx[MW-1:0];
			ay_s2  <= my[MW-1:0];
			sx_s2  <= nx[NW-1];
			sy_s2  <= ny[NW-1];
			rgb_s2 <= rgb_s1;
		end
	end

	// stage 3: per-byte bit length of the largest magnitude
	logic          v_s3;
	logic [MW-1:0] ax_s3, ay_s3;
	logic          sx_s3, sy_s3;
	csh_rgb_t      rgb_s3;
	logic          nz_s3  [NG];
	logic [3:0]    len_s3 [NG];
	logic [PW-1:0] word;

	assign word = PW'(ax_s2 | ay_s2 | ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < NG; g++) begin
				nz_s3[g]  <= |word[g*8 +: 8];
				len_s3[g] <= bitlen8(word[g*8 +: 8]);
			end
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			sx_s3  <= sx_s2;
			sy_s3  <= sy_s2;
			rgb_s3 <= rgb_s2;
		end
	end

	// stage 4: pick the top nonzero byte
	logic           v_s4;
	logic [MW-1:0]  ax_s4, ay_s4;
	logic           sx_s4, sy_s4;
	csh_rgb_t       rgb_s4;
	logic [BLW-1:0] bl_s4;
	logic [BLW-1:0] bl;

	always_comb begin
		bl = '0;
		for (int g = 0; g < NG; g++) begin
			if (nz_s3[g]) bl = BLW'(g * 8) + BLW'(len_s3[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bl_s4  <= bl;
			ax_s4  <= ax_s3;
			ay_s4  <= ay_s3;
			sx_s4  <= sx_s3;
			sy_s4  <= sy_s3;
			rgb_s4 <= rgb_s3;
		end
	end

	// stage 5: shift all three so the largest sits just below bit 30
	logic              v_s5;
	logic [NORM_W-1:0] vx_s5, vy_s5, u_s5;
	logic              sx_s5, sy_s5;
	csh_rgb_t          rgb_s5;
	logic [BLW-1:0]    sh_r, sh_l;
	logic              go_right;

	assign go_right = bl_s4 > BLW'(NORM_W);
	assign sh_r     = bl_s4 - BLW'(NORM_W);
	assign sh_l     = BLW'(NORM_W) - bl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (go_right) begin
				vx_s5 <= NORM_W'(ax_s4 >> sh_r);
				vy_s5 <= NORM_W'(ay_s4 >> sh_r);
				u_s5  <= NORM_W'(ONE >> sh_r);
			end else begin
				vx_s5 <= NORM_W'(ax_s4 << sh_l);
				vy_s5 <= NORM_W'(ay_s4 << sh_l);
				u_s5  <= NORM_W'(ONE << sh_l);
			end
			sx_s5  <= sx_s4;
			sy_s5  <= sy_s4;
			rgb_s5 <= rgb_s4;
		end
	end

	// stage 6: light products and squares
	logic                   v_s6;
	logic signed [45:0]     pz_s6, py_s6, px_s6;
	logic [2*NORM_W-1:0]    qx_s6, qy_s6, qu_s6;
	csh_rgb_t               rgb_s6;
	logic signed [NORM_W:0] svx, svy, su;

	always_comb begin
		svx = sx_s5 ? -$signed({1'b0, vx_s5}) : $signed({1'b0, vx_s5});
		svy = sy_s5 ? -$signed({1'b0, vy_s5}) : $signed({1'b0, vy_s5});
		su  = $signed({1'b0, u_s5});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pz_s6  <= cfg.light_z * su;
			py_s6  <= cfg.light_y * svy;
			px_s6  <= cfg.light_x * svx;
			qx_s6  <= vx_s5 * vx_s5;
			qy_s6  <= vy_s5 * vy_s5;
			qu_s6  <= u_s5 * u_s5;
			rgb_s6 <= rgb_s5;
		end
	end

	// stage 7: sums
	logic                    v_s7;
	logic signed [NUM_W-1:0] num_s7;
	logic [DEN_W-1:0]        den_s7;
	csh_rgb_t                rgb_s7;
	logic signed [NUM_W-1:0] num;

	assign num = pz_s6 + py_s6 + px_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s7 <= num;
			den_s7 <= DEN_W'(qx_s6) + DEN_W'(qy_s6) + DEN_W'(qu_s6);
			rgb_s7 <= rgb_s6;
		end
	end

	assign out_v = v_s7;
	assign out_d = '{num_s7, den_s7, rgb_s7};

endmodule

### rtl/core/csh_sqrt.sv
// pipelined integer square root, one result bit per stage
module csh_sqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  csh_pkg::csh_nd_t in_d,
	output logic             out_v,
	output csh_pkg::csh_nr_t out_d
);
	import csh_pkg::*;

	localparam int TW = DEN_W + 1;

	logic                    v_s    [ROOT_W];
	logic [ROOT_W-1:0]       root_s [ROOT_W];
	logic [DEN_W-1:0]        rem_s  [ROOT_W];
	logic signed [NUM_W-1:0] num_s  [ROOT_W];
	csh_rgb_t                rgb_s  [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		localparam int B = ROOT_W - 1 - k;

		logic                    pv;
		logic [ROOT_W-1:0]       proot;
		logic [DEN_W-1:0]        prem;
		logic signed [NUM_W-1:0] pnum;
		csh_rgb_t                prgb;
		logic [TW-1:0]           trial;
		logic                    fit;

		if (k == 0) begin : g_first
			assign pv    = in_v;
			assign proot = '0;
			assign prem  = in_d.den;
			assign pnum  = in_d.num;
			assign prgb  = in_d.rgb;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign proot = root_s[k-1];
			assign prem  = rem_s[k-1];
			assign pnum  = num_s[k-1];
			assign prgb  = rgb_s[k-1];
		end

		// try setting this root bit against the running remainder
		assign trial = (TW'(proot) << (B + 1)) | (TW'(1) << (2 * B));
		assign fit   = {1'b0, prem} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (en) v_s[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= fit ? (proot | (ROOT_W'(1) << B)) : proot;
				rem_s[k]  <= fit ? DEN_W'({1'b0, prem} - trial) : prem;
				num_s[k]  <= pnum;
				rgb_s[k]  <= prgb;
			end
		end
	end

	assign out_v = v_s[ROOT_W-1];
	assign out_d = '{num_s[ROOT_W-1], root_s[ROOT_W-1], rgb_s[ROOT_W-1]};

endmodule

### rtl/core/csh_div.sv
// rounded cosine quotient, ambient sum and channel scaling
module csh_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        ambient_level,
	input  logic              in_v,
	input  csh_pkg::csh_nr_t  in_d,
	output logic              out_v,
	output csh_pkg::csh_out_t out_d
);
	import csh_pkg::*;

	// round(a * 65536 / 255) = 257a plus one for the upper half
	function automatic logic [INT_W-1:0] amb_q16(input logic [7:0] a);
		return INT_W'(a) * INT_W'(257) + INT_W'(a[7]);
	endfunction

	function automatic logic [COLOR_W-1:0] scale_ch(input logic [INT_W-1:0] inten,
		input logic [COLOR_W-1:0] col);
		logic [INT_W+COLOR_W:0] p;
		logic [INT_W+COLOR_W-16:0] c;
		p = (INT_W+COLOR_W+1)'(inten) * (INT_W+COLOR_W+1)'(col)
			+ (INT_W+COLOR_W+1)'(32768);
		c = p[INT_W+COLOR_W:16];
		return (c > (INT_W+COLOR_W-15)'(255)) ? COLOR_W'(255) : COLOR_W'(c);
	endfunction

	// stage 1: dividend 2x+d and divisor 2d
	logic              v_s1;
	logic [DVD_W-1:0]  n_s1;
	logic [DVS_W-1:0]  dvs_s1;
	csh_rgb_t          rgb_s1;
	logic [NUM_W+6:0]  xm;
	logic [DVS_W-2:0]  d;
	logic              pos;

	always_comb begin
		pos = in_d.num > 0;
		xm  = in_d.num[NUM_W-2:0] * 8'(~ambient_level);
		d   = (DVS_W-1)'({in_d.root, 8'b0}) - (DVS_W-1)'(in_d.root);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1   <= pos ? (DVD_W'({xm, 3'b000}) + DVD_W'(d)) : '0;
			dvs_s1 <= {d, 1'b0};
			rgb_s1 <= in_d.rgb;
		end
	end

	// restoring division, one quotient bit per stage
	logic             v_s   [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];
	logic [DVD_W-1:0] rem_s [QUO_W];
	logic [DVS_W-1:0] dvs_s [QUO_W];
	csh_rgb_t         rgb_s [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		localparam int B = QUO_W - 1 - k;

		logic             pv;
		logic [QUO_W-1:0] pquo;
		logic [DVD_W-1:0] prem;
		logic [DVS_W-1:0] pdvs;
		csh_rgb_t         prgb;
		logic [DVD_W-1:0] sub;
		logic             fit;

		if (k == 0) begin : g_first
			assign pv   = v_s1;
			assign pquo = '0;
			assign prem = n_s1;
			assign pdvs = dvs_s1;
			assign prgb = rgb_s1;
		end else begin : g_next
			assign pv   = v_s[k-1];
			assign pquo = quo_s[k-1];
			assign prem = rem_s[k-1];
			assign pdvs = dvs_s[k-1];
			assign prgb = rgb_s[k-1];
		end

		assign sub = DVD_W'(pdvs) << B;
		assign fit = prem >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (en) v_s[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= fit ? (pquo | (QUO_W'(1) << B)) : pquo;
				rem_s[k] <= fit ? (prem - sub) : prem;
				dvs_s[k] <= pdvs;
				rgb_s[k] <= prgb;
			end
		end
	end

	// stage 2: intensity, saturated
	logic             v_s2;
	logic [INT_W-1:0] inten_s2;
	csh_rgb_t         rgb_s2;
	logic [QUO_W:0]   isum;

	assign isum = (QUO_W+1)'(amb_q16(ambient_level)) + (QUO_W+1)'(quo_s[QUO_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s[QUO_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inten_s2 <= (isum > (QUO_W+1)'(INT_MAX)) ? INT_MAX : isum[INT_W-1:0];
			rgb_s2   <= rgb_s[QUO_W-1];
		end
	end

	// stage 3: scale each channel
	logic     v_s3;
	csh_out_t shade_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			shade_s3.shade_red   <= scale_ch(inten_s2, rgb_s2.red);
			shade_s3.shade_green <= scale_ch(inten_s2, rgb_s2.green);
			shade_s3.shade_blue  <= scale_ch(inten_s2, rgb_s2.blue);
		end
	end

	assign out_v = v_s3;
	assign out_d = shade_s3;

endmodule

### rtl/core/cushion_pixel_shader_unit.sv
// Cushion treemap pixel shader: returns one shaded colour per pixel (7 front stages for the
// surface normal, its normalization and light products, 31 square root stages, 1 + 18
// division stages, 2 stages of intensity and channel scaling, and the output register).
// It takes one pixel every cycle while the skid buffer is empty; while a result waits the
// pipeline keeps moving until the next result lands in a one-entry skid buffer, after which
// the whole pipeline holds and pix_stall holds the input until the waiting result is taken.
// The user must write surface coefficients, light direction and ambient level over the
// register port only while no pixel is in flight; the block itself does not enforce this.
module cushion_pixel_shader_unit #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pix_valid,
	output logic                       pix_stall,
	input  csh_pkg::csh_in_t           pix,
	output logic                       shade_valid,
	input  logic                       shade_stall,
	output csh_pkg::csh_out_t          shade,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [csh_pkg::ADDR_W-1:0] paddr,
	input  logic [csh_pkg::DATA_W-1:0] pwdata,
	output logic [csh_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import csh_pkg::*;

	csh_cfg_t cfg_q;
	csh_reg_t reg_sel;
	logic     en;

	assign reg_sel = csh_reg_t'(paddr[ADDR_W-1:2]);
	assign pready  = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_AMBIENT: cfg_q.ambient_level <= pwdata[7:0];
				REG_LIGHT_X: cfg_q.light_x       <= pwdata[15:0];
				REG_LIGHT_Y: cfg_q.light_y       <= pwdata[15:0];
				REG_LIGHT_Z: cfg_q.light_z       <= pwdata[15:0];
				REG_LIN_X:   cfg_q.lin_coef_x    <= pwdata;
				REG_SQ_X:    cfg_q.sq_coef_x     <= pwdata;
				REG_LIN_Y:   cfg_q.lin_coef_y    <= pwdata;
				REG_SQ_Y:    cfg_q.sq_coef_y     <= pwdata;
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_sel)
			REG_AMBIENT: prdata = DATA_W'(cfg_q.ambient_level);
			REG_LIGHT_X: prdata = DATA_W'($unsigned(cfg_q.light_x));
			REG_LIGHT_Y: prdata = DATA_W'($unsigned(cfg_q.light_y));
			REG_LIGHT_Z: prdata = DATA_W'($unsigned(cfg_q.light_z));
			REG_LIN_X:   prdata = cfg_q.lin_coef_x;
			REG_SQ_X:    prdata = cfg_q.sq_coef_x;
			REG_LIN_Y:   prdata = cfg_q.lin_coef_y;
			REG_SQ_Y:    prdata = cfg_q.sq_coef_y;
			default:     prdata = '0;
		endcase
	end

	// datapath
	logic     nd_v, nr_v, pipe_v;
	csh_nd_t  nd_d;
	csh_nr_t  nr_d;
	csh_out_t pipe_d;

	csh_front #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.in_v  (pix_valid),
		.in_d  (pix),
		.cfg   (cfg_q),
		.out_v (nd_v),
		.out_d (nd_d)
	);

	csh_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.in_v  (nd_v),
		.in_d  (nd_d),
		.out_v (nr_v),
		.out_d (nr_d)
	);

	csh_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.ambient_level(cfg_q.ambient_level),
		.in_v         (nr_v),
		.in_d         (nr_d),
		.out_v        (pipe_v),
		.out_d        (pipe_d)
	);

	// output register with one skid entry; the pipeline holds while the skid is full
	logic     out_v_q, skid_v_q;
	csh_out_t out_q, skid_q;

	assign en          = !skid_v_q;
	assign pix_stall   = skid_v_q;
	assign shade_valid = out_v_q;
	assign shade       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!shade_stall) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || !shade_stall) begin
			out_v_q <= pipe_v;
		end else if (pipe_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!shade_stall) out_q <= skid_q;
		end else if (!out_v_q || !shade_stall) begin
			out_q <= pipe_d;
		end else begin
			skid_q <= pipe_d;
		end
	end

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without a pending output transaction");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && shade_stall && pipe_v))
		else $error("skid filled while output was free");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !shade_stall) |=> (!skid_v_q && out_v_q))
		else $error("skid entry not moved to output after transaction");
`endif

endmodule
